FILE: rtl/dht_peer_bucket_table_top_assert.svh
// Assertion macros for the peer bucket table
`ifndef DHT_PEER_BUCKET_TABLE_TOP_ASSERT_SVH
`define DHT_PEER_BUCKET_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DPB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/dpb_pkg.sv
package dpb_pkg;

    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int IPV4_W  = 32;
    localparam int PORT_W  = 16;
    localparam int KEY_W   = 64;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP     = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFND  = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLOSEST = 3'd5;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_FINDCHK,
        S_FSCAN,
        S_FEMIT,
        S_FREAD,
        S_OUT
    } state_t;

    // one result item as handed to the output register
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  id;
        logic [IPV4_W-1:0] ipv4;
        logic [PORT_W-1:0] port;
        logic              last;
    } result_t;

endpackage

FILE: rtl/dht_peer_bucket_table_top.sv
// Peer routing table of ID_WIDTH+1 distance buckets, BUCKET_CAPACITY slots
// each, held in one slot memory; the fill count of each bucket sits in a
// second small memory. After reset a clearing pass zeroes the fill counts of
// all buckets; s_tready stays low meanwhile. One item at a time: s_tready
// is high only when idle and no result item is waiting. Add and remove first
// count the id distance, then scan the bucket one slot per cycle (remove
// also shifts the tail down, one slot per cycle). Find takes one full pass
// over all buckets per result, so up to BUCKET_CAPACITY passes; the single
// read port of the slot memory sets this. Results wait in an output register.
module dht_peer_bucket_table_top
    import dpb_pkg::*;
#(
    parameter int ID_WIDTH        = 64,
    parameter int BUCKET_CAPACITY = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: opcode[1:0], key[65:2], ipv4[97:66], port[113:98]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0], out_id[66:3], out_ipv4[98:67], out_port[114:99]
    output logic [119:0] m_tdata,
    output logic         m_tlast
);
    `include "dht_peer_bucket_table_top_assert.svh"

    localparam int NB    = ID_WIDTH + 1;
    localparam int BW    = $clog2(NB);
    localparam int SW    = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
    localparam int FW    = $clog2(BUCKET_CAPACITY + 1);
    localparam int DEPTH = NB * BUCKET_CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = ID_WIDTH + IPV4_W + PORT_W;
    localparam int TW    = $clog2(DEPTH + 1);

    state_t state_reg, state_next;

    logic [ID_WIDTH-1:0]      own_reg;
    logic [OP_W-1:0]          op_reg;
    logic [ID_WIDTH-1:0]      key_reg;
    logic [IPV4_W-1:0]        ip_reg;
    logic [PORT_W-1:0]        port_reg;
    logic [BW-1:0]            bkt_reg, bkt_next;
    logic [SW:0]              idx_reg, idx_next;
    logic [BW-1:0]            clr_reg, clr_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic [BW-1:0]            rb_reg;
    logic [SW-1:0]            ri_reg;
    logic                     have_reg, have_next;
    logic [ID_WIDTH-1:0]      best_reg, best_next;
    logic [BW-1:0]            bb_reg, bb_next;
    logic [SW-1:0]            bi_reg, bi_next;
    logic [ID_WIDTH-1:0]      pdist_reg, pdist_next;
    logic [BW-1:0]            pb_reg, pb_next;
    logic [SW-1:0]            pi_reg, pi_next;
    logic [FW-1:0]            want_reg, want_next, k_reg, k_next;
    logic [TW-1:0]            total_reg;
    result_t                  res_reg;
    logic                     ovalid_reg;

    logic                     in_acc, out_acc;
    logic                     pc_start, pc_done;
    logic [BW-1:0]            pc_count;
    logic                     we;
    logic [AW-1:0]            waddr, raddr;
    logic [EW-1:0]            wdata, rdata;
    logic                     rd_en;
    logic [BW-1:0]            rb;
    logic [SW-1:0]            ri;
    logic                     emit;
    result_t                  res_next;
    logic [ID_WIDTH-1:0]      rid, xdist;
    logic [IPV4_W-1:0]        rip;
    logic [PORT_W-1:0]        rport;
    logic [FW-1:0]            fill_b;
    logic                     f_we, f_re;
    logic [BW-1:0]            f_waddr, f_raddr;
    logic [FW-1:0]            f_wdata;
    logic                     fill_inc, fill_dec;
    logic                     elig;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;

    function automatic logic [AW-1:0] addr_of(logic [BW-1:0] b, logic [SW-1:0] i);
        logic [AW:0] a;
        a = (AW+1)'(b) * (AW+1)'(BUCKET_CAPACITY) + (AW+1)'(i);
        return a[AW-1:0];
    endfunction

    dpb_popcount #(.ID_WIDTH(ID_WIDTH), .BW(BW)) u_pop (
        .clk(clk), .rst_n(rst_n), .start(pc_start),
        .value(s_tdata[2 +: ID_WIDTH] ^ own_reg), .done(pc_done), .count(pc_count)
    );

    dpb_slot_ram #(.DEPTH(DEPTH), .WIDTH(EW), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(rd_en), .raddr(raddr), .rdata(rdata)
    );

    dpb_slot_ram #(.DEPTH(NB), .WIDTH(FW), .AW(BW)) u_fill (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .re(f_re), .raddr(f_raddr), .rdata(fill_b)
    );

    assign rid   = rdata[EW-1 -: ID_WIDTH];
    assign rip   = rdata[PORT_W +: IPV4_W];
    assign rport = rdata[PORT_W-1:0];
    assign xdist = rid ^ key_reg;
    assign raddr = addr_of(rb, ri);

    // a slot still counts in this pass if it comes after the last result
    assign elig = (k_reg == '0) || (xdist > pdist_reg)
                  || (xdist == pdist_reg && {rb_reg, ri_reg} > {pb_reg, pi_reg});

    // total peers for find, kept alongside the fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (fill_inc)
            total_reg <= total_reg + 1'b1;
        else if (fill_dec)
            total_reg <= total_reg - 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_reg == BW'(NB - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_acc)
                begin
                    if (s_tdata[1:0] == OP_FIND)
                        state_next = S_FINDCHK;
                    else if (s_tdata[1:0] == OP_ADD || s_tdata[1:0] == OP_REMOVE)
                        state_next = S_POP;
                end
            S_POP:
                if (pc_done)
                    state_next = S_SCAN;
            S_SCAN:
                if (rd_pend_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (rid == key_reg && rip == ip_reg && rport == port_reg)
                            state_next = S_OUT;
                        else if (idx_reg == (SW+1)'(fill_b))
                            state_next = S_OUT;
                    end
                    else if (rid == key_reg)
                        state_next = S_SHIFT;
                    else if (idx_reg == (SW+1)'(fill_b))
                        state_next = S_OUT;
                end
                else if (fill_b == '0)
                    state_next = S_OUT;
            S_SHIFT:
                if (idx_reg == (SW+1)'(fill_b))
                    state_next = S_OUT;
            S_FINDCHK:
                state_next = S_FSCAN;
            S_FSCAN:
                if (bkt_reg == BW'(NB - 1) && (SW+1)'(fill_b) <= idx_reg && !rd_pend_reg)
                    state_next = S_FREAD;
                else if (total_reg == '0)
                    state_next = S_OUT;
            S_FREAD:
                state_next = S_FEMIT;
            S_FEMIT:
                if (!ovalid_reg || out_acc)
                    state_next = (k_reg + 1'b1 == want_reg) ? S_IDLE : S_FSCAN;
            S_OUT:
                if (!ovalid_reg || out_acc)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        bkt_next     = bkt_reg;
        idx_next     = idx_reg;
        clr_next     = clr_reg;
        rd_pend_next = 1'b0;
        have_next    = have_reg;
        best_next    = best_reg;
        bb_next      = bb_reg;
        bi_next      = bi_reg;
        pdist_next   = pdist_reg;
        pb_next      = pb_reg;
        pi_next      = pi_reg;
        want_next    = want_reg;
        k_next       = k_reg;
        pc_start     = 1'b0;
        we           = 1'b0;
        waddr        = addr_of(bkt_reg, idx_reg[SW-1:0]);
        wdata        = {key_reg, ip_reg, port_reg};
        rd_en        = 1'b0;
        rb           = bkt_reg;
        ri           = idx_reg[SW-1:0];
        f_we         = 1'b0;
        f_re         = 1'b0;
        f_waddr      = bkt_reg;
        f_raddr      = bkt_reg;
        f_wdata      = fill_b;
        emit         = 1'b0;
        res_next     = '{status: ST_ADDED, id: '0, ipv4: '0, port: '0, last: 1'b1};
        fill_inc     = 1'b0;
        fill_dec     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                // zero one fill count per cycle
                f_we     = 1'b1;
                f_waddr  = clr_reg;
                f_wdata  = '0;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
                if (in_acc)
                    pc_start = 1'b1;
            S_POP:
                if (pc_done)
                begin
                    bkt_next = pc_count;
                    idx_next = '0;
                    f_re     = 1'b1;
                    f_raddr  = pc_count;
                end
            S_SCAN:
            begin
                // issue the read of slot idx while checking the previous one
                if (rd_pend_reg && op_reg == OP_ADD
                    && rid == key_reg && rip == ip_reg && rport == port_reg)
                    res_next.status = ST_DUP;
                else if (rd_pend_reg && op_reg == OP_REMOVE && rid == key_reg)
                    rd_pend_next = 1'b0;
                else if (idx_reg < (SW+1)'(fill_b))
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
                if (op_reg == OP_ADD)
                begin
                    if (fill_b == FW'(BUCKET_CAPACITY))
                        res_next.status = ST_FULL;
                    else
                        res_next.status = ST_ADDED;
                    if (rd_pend_reg && rid == key_reg && rip == ip_reg
                        && rport == port_reg)
                        res_next.status = ST_DUP;
                end
                else
                    res_next.status = ST_NOTFND;
                if (state_next == S_OUT)
                    emit = 1'b1;
                if (state_next == S_OUT && op_reg == OP_ADD
                    && res_next.status == ST_ADDED)
                begin
                    we       = 1'b1;
                    waddr    = addr_of(bkt_reg, fill_b[SW-1:0]);
                    fill_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // idx points at the slot after the match; move it down one
                if (rd_pend_reg)
                begin
                    we    = 1'b1;
                    waddr = addr_of(bkt_reg, SW'(idx_reg - 2'd2));
                    wdata = rdata;
                end
                if (idx_reg < (SW+1)'(fill_b))
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
                else
                begin
                    res_next.status = ST_REMOVED;
                    emit     = 1'b1;
                    fill_dec = 1'b1;
                end
            end
            S_FINDCHK:
            begin
                bkt_next  = '0;
                idx_next  = '0;
                have_next = 1'b0;
                k_next    = '0;
                f_re      = 1'b1;
                f_raddr   = '0;
                want_next = (total_reg < TW'(BUCKET_CAPACITY)) ? FW'(total_reg)
                                                               : FW'(BUCKET_CAPACITY);
            end
            S_FSCAN:
            begin
                if (total_reg == '0)
                begin
                    res_next.status = ST_EMPTY;
                    emit = 1'b1;
                end
                // compare the slot read last cycle
                if (rd_pend_reg && elig && (!have_reg || xdist < best_reg))
                begin
                    have_next = 1'b1;
                    best_next = xdist;
                    bb_next   = rb_reg;
                    bi_next   = ri_reg;
                end
                // walk bucket by bucket, slot by slot
                if (idx_reg < (SW+1)'(fill_b))
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
                else if (bkt_reg != BW'(NB - 1))
                begin
                    bkt_next = bkt_reg + 1'b1;
                    idx_next = '0;
                    f_re     = 1'b1;
                    f_raddr  = bkt_reg + 1'b1;
                end
            end
            S_FREAD:
            begin
                rd_en = 1'b1;
                rb    = bb_reg;
                ri    = bi_reg;
            end
            S_FEMIT:
            begin
                res_next = '{status: ST_CLOSEST, id: KEY_W'(rid), ipv4: rip, port: rport,
                             last: (k_reg + 1'b1 == want_reg)};
                if (!ovalid_reg || out_acc)
                begin
                    emit       = 1'b1;
                    pdist_next = best_reg;
                    pb_next    = bb_reg;
                    pi_next    = bi_reg;
                    k_next     = k_reg + 1'b1;
                    bkt_next   = '0;
                    idx_next   = '0;
                    have_next  = 1'b0;
                    f_re       = 1'b1;
                    f_raddr    = '0;
                end
            end
            default:
                ;
        endcase
        // update the fill count of the current bucket
        if (fill_inc)
        begin
            f_we    = 1'b1;
            f_wdata = fill_b + 1'b1;
        end
        else if (fill_dec)
        begin
            f_we    = 1'b1;
            f_wdata = fill_b - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            own_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rd_pend_reg <= rd_pend_next;
            if (cfg_we)
                own_reg <= cfg_wdata[ID_WIDTH-1:0];
            if (emit)
                ovalid_reg <= 1'b1;
            else if (out_acc)
                ovalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= s_tdata[1:0];
            key_reg  <= s_tdata[2 +: ID_WIDTH];
            ip_reg   <= s_tdata[66 +: IPV4_W];
            port_reg <= s_tdata[98 +: PORT_W];
        end
        bkt_reg   <= bkt_next;
        idx_reg   <= idx_next;
        have_reg  <= have_next;
        best_reg  <= best_next;
        bb_reg    <= bb_next;
        bi_reg    <= bi_next;
        pdist_reg <= pdist_next;
        pb_reg    <= pb_next;
        pi_reg    <= pi_next;
        want_reg  <= want_next;
        k_reg     <= k_next;
        rb_reg    <= rb;
        ri_reg    <= ri;
        if (emit)
            res_reg <= res_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, res_reg.port, res_reg.ipv4, res_reg.id, res_reg.status};
    assign m_tlast  = res_reg.last;

    `DPB_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "result item dropped while stalled")
    `DPB_ASSERT_IMP(a_idle_only, clk, rst_n, s_tready, state_reg == S_IDLE && !ovalid_reg,
        "input taken while busy")
    `DPB_ASSERT_IMP(a_one_write, clk, rst_n, fill_inc, !fill_dec,
        "fill count moved both ways")
endmodule

FILE: rtl/dpb_popcount.sv
// Count set bits of the id distance, four bits per cycle
module dpb_popcount
    import dpb_pkg::*;
#(
    parameter int ID_WIDTH = 64,
    parameter int BW       = 7
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ID_WIDTH-1:0] value,
    output logic                done,
    output logic [BW-1:0]       count
);
    localparam int NSTEP = (ID_WIDTH + 3) / 4;
    localparam int PADW  = NSTEP * 4;
    localparam int CW    = $clog2(NSTEP + 1);

    logic [PADW-1:0] sh_reg, sh_next;
    logic [BW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   step_reg, step_next;
    logic            busy_reg, busy_next;
    logic [2:0]      nib;

    // add the low nibble each step
    always_comb
    begin
        nib       = 3'(sh_reg[0]) + 3'(sh_reg[1]) + 3'(sh_reg[2]) + 3'(sh_reg[3]);
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            sh_next   = PADW'(value);
            cnt_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next   = sh_reg >> 4;
            cnt_next  = cnt_reg + BW'(nib);
            step_next = step_reg + 1'b1;
            if (step_reg == CW'(NSTEP - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    assign done  = busy_reg && (step_reg == CW'(NSTEP - 1));
    assign count = cnt_next;
endmodule

FILE: rtl/dpb_slot_ram.sv
// Simple dual-port memory: one write port, one registered read port with enable
module dpb_slot_ram
    import dpb_pkg::*;
#(
    parameter int DEPTH = 1040,
    parameter int WIDTH = 112,
    parameter int AW    = 11
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write, and read only when asked so the data holds otherwise
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

FILE: tb/dht_peer_bucket_table_top_tb.sv
`timescale 1ns / 100ps

module dht_peer_bucket_table_top_tb
    import dpb_pkg::*;
();

    localparam int CAP = 16;
    localparam int NB = 65;
    localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

    // one expected result item
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [63:0]       id;
        logic [31:0]       ipv4;
        logic [15:0]       port;
        logic              last;
    } peer_result_t;

    typedef struct {
        logic [63:0] id;
        logic [31:0] ipv4;
        logic [15:0] port;
    } peer_t;

    // routing table mirror and result checker
    class peer_table_scoreboard;
        peer_t        buckets[NB][CAP];
        int           fill[NB];
        logic [63:0]  own_id;
        peer_result_t pending[$];
        int           mismatches;

        function new();
            own_id = '0;
            mismatches = 0;
            foreach (fill[b]) fill[b] = 0;
        endfunction

        function int bucket_index(logic [63:0] id);
            return $countones(id ^ own_id);
        endfunction

        function void push(logic [STAT_W-1:0] st, peer_t p, logic lst);
            peer_result_t r;
            r.status = st;
            r.id = p.id;
            r.ipv4 = p.ipv4;
            r.port = p.port;
            r.last = lst;
            pending.insert(pending.size(), r);
        endfunction

        // apply one accepted item to the table and queue its results
        function void note_item(logic [1:0] op, logic [63:0] key,
                                logic [31:0] ip, logic [15:0] port);
            peer_t none;
            peer_t p;
            int b;
            int total;
            int want;
            int bb;
            int bi;
            bit have;
            bit done;
            logic [63:0] best;
            logic [63:0] d;
            bit taken[NB][CAP];
            none = '{64'd0, 32'd0, 16'd0};
            if (op == OP_ADD)
            begin
                b = bucket_index(key);
                done = 0;
                for (int i = 0; i < fill[b]; i++)
                    if (!done && buckets[b][i].id == key && buckets[b][i].ipv4 == ip
                        && buckets[b][i].port == port)
                        done = 1;
                if (done)
                    push(ST_DUP, none, 1'b1);
                else if (fill[b] >= CAP)
                    push(ST_FULL, none, 1'b1);
                else
                begin
                    buckets[b][fill[b]] = '{key, ip, port};
                    fill[b]++;
                    push(ST_ADDED, none, 1'b1);
                end
            end
            else if (op == OP_REMOVE)
            begin
                b = bucket_index(key);
                done = 0;
                for (int i = 0; i < fill[b]; i++)
                    if (!done && buckets[b][i].id == key)
                    begin
                        for (int j = i; j + 1 < fill[b]; j++)
                            buckets[b][j] = buckets[b][j+1];
                        fill[b]--;
                        done = 1;
                    end
                push(done ? ST_REMOVED : ST_NOTFND, none, 1'b1);
            end
            else if (op == OP_FIND)
            begin
                total = 0;
                foreach (fill[i]) total += fill[i];
                if (total == 0)
                    push(ST_EMPTY, none, 1'b1);
                else
                begin
                    want = total < CAP ? total : CAP;
                    foreach (taken[i, j]) taken[i][j] = 0;
                    for (int k = 0; k < want; k++)
                    begin
                        have = 0;
                        bb = 0;
                        bi = 0;
                        best = '0;
                        for (int x = 0; x < NB; x++)
                            for (int i = 0; i < fill[x]; i++)
                            begin
                                d = buckets[x][i].id ^ key;
                                if (!taken[x][i] && (!have || d < best))
                                begin
                                    have = 1;
                                    best = d;
                                    bb = x;
                                    bi = i;
                                end
                            end
                        taken[bb][bi] = 1;
                        p = buckets[bb][bi];
                        push(ST_CLOSEST, p, k + 1 == want);
                    end
                end
            end
        endfunction

        function void check_result(logic [119:0] data, logic lst);
            peer_result_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h last %b", data, lst);
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.status || data[66:3] !== e.id || data[98:67] !== e.ipv4
                || data[114:99] !== e.port || data[119:115] !== 5'd0 || lst !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %h %h %h %b, got %0d %h %h %h %b",
                             e.status, e.id, e.ipv4, e.port, e.last,
                             data[2:0], data[66:3], data[98:67], data[114:99], lst);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [63:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         m_tlast;

    peer_table_scoreboard sb;
    longint unsigned cycles;
    int hold_off;
    logic [63:0] pool[$];
    logic [31:0] pool_ip[$];
    logic [15:0] pool_port[$];

    dht_peer_bucket_table_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            phase++;
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if ((phase / 200) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // offer one item, hold until accepted
    task automatic send_item(logic [1:0] op, logic [63:0] key, logic [31:0] ip,
                             logic [15:0] port);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, port, ip, key, op};
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, key, ip, port);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // wait for every result, then a settle pause
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_own_id(logic [63:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.own_id = v;
    endtask

    // id with a chosen distance from own_id
    function automatic logic [63:0] id_at_distance(int ndist);
        logic [63:0] m;
        int pos;
        m = '0;
        while ($countones(m) < ndist)
        begin
            pos = $urandom_range(0, 63);
            m[pos] = 1'b1;
        end
        return sb.own_id ^ m;
    endfunction

    task automatic random_item();
        int r;
        int k;
        logic [63:0] key;
        logic [31:0] ip;
        logic [15:0] port;
        r = $urandom_range(0, 99);
        key = {$urandom, $urandom};
        ip = $urandom;
        port = 16'($urandom);
        if (r < 45)
        begin
            // add, half of new keys clustered into few buckets, sometimes a repeat
            if (pool.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(0, pool.size() - 1);
                send_item(OP_ADD, pool[k], pool_ip[k], pool_port[k]);
                return;
            end
            if ($urandom_range(0, 1))
                key = id_at_distance($urandom_range(0, 3) == 0 ? 64 : $urandom_range(0, 3));
            pool.insert(pool.size(), key);
            pool_ip.insert(pool_ip.size(), ip);
            pool_port.insert(pool_port.size(), port);
            send_item(OP_ADD, key, ip, port);
        end
        else if (r < 70)
        begin
            if (pool.size() > 0 && $urandom_range(0, 3) != 0)
                key = pool[$urandom_range(0, pool.size() - 1)];
            send_item(OP_REMOVE, key, ip, port);
        end
        else if (r < 97)
            send_item(OP_FIND, key, ip, port);
        else
            send_item(OP_UNUSED, key, ip, port);
    endtask

    initial
    begin
        logic [63:0] fid;
        sb = new();
        hold_off = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, misses, extremes, duplicate, full bucket
        send_item(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_REMOVE, 64'd0, 32'd0, 16'd0);
        send_item(OP_ADD, 64'd0, 32'd0, 16'd0);
        send_item(OP_ADD, 64'd0, 32'd0, 16'd0);
        send_item(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_FIND, 64'd0, 32'd0, 16'd0);
        fid = 64'd1;
        for (int i = 0; i < CAP + 1; i++)
            send_item(OP_ADD, fid << i, 32'(i), 16'(i));
        send_item(OP_FIND, 64'h0, 32'h0, 16'h0);
        send_item(OP_REMOVE, fid << 3, 32'h0, 16'h0);
        send_item(OP_FIND, 64'h8, 32'h0, 16'h0);

        // pause until all results are in, then change own_id
        write_own_id(64'hFFFF_FFFF_FFFF_FFFF);

        // long receiver hold-off while items keep coming
        hold_off = 3000;
        for (int i = 0; i < 20; i++)
            random_item();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < 45; i++)
            begin
                random_item();
                idle_gap();
            end
            case (ph)
                0: write_own_id(64'd0);
                1: write_own_id({$urandom, $urandom});
                default: write_own_id(64'h5555_AAAA_0F0F_F0F0);
            endcase
        end

        drain();
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_popcount.sv
rtl/dpb_slot_ram.sv
rtl/dht_peer_bucket_table_top.sv
tb/dht_peer_bucket_table_top_tb.sv
